// File: rtl/fcrp_pkg.sv
// ----------------------------------------------------------------------------
// fcrp_pkg
// Shared types and constants for the FTP control reply parser.
// ----------------------------------------------------------------------------
package fcrp_pkg;

   localparam logic [9:0] CODE_PASV = 10'd227;
   localparam logic [9:0] CODE_RETR = 10'd150;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_MISMATCH   = 2'd1,
      STATUS_INCOMPLETE = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] reply_char;
      logic       last_char;
      logic [9:0] expected_code;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  reply_code;
      logic [31:0] ip_address;
      logic [15:0] port_number;
      logic [31:0] file_length;
   } rsp_type;

   // classified character, front to back
   typedef struct packed {
      logic       is_digit;
      logic [3:0] digit;
      logic       is_lparen;
      logic       is_rparen;
      logic       is_comma;
      logic       is_space;
      logic       is_pasv;
      logic       is_retr;
      logic       last_char;
      logic [9:0] expected_code;
   } cls_type;

endpackage

// File: rtl/fcrp_front.sv
// ----------------------------------------------------------------------------
// fcrp_front
// Accepts reply characters, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module fcrp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  fcrp_pkg::req_type req_data,
   output logic             cls_valid,
   output fcrp_pkg::cls_type cls_data,
   input  logic             cls_take
);
   import fcrp_pkg::*;

   localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

   cls_type             queue_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff,  count_in;
   cls_type             cls_new;
   logic                wr_en;
   logic                rd_en;

   always_comb begin
      cls_new.is_digit      = (req_data.reply_char >= CHAR_ZERO) &&
                              (req_data.reply_char <= CHAR_NINE);
      cls_new.digit         = cls_new.is_digit ? req_data.reply_char[3:0] : 4'd0;
      cls_new.is_lparen     = (req_data.reply_char == CHAR_LPAREN);
      cls_new.is_rparen     = (req_data.reply_char == CHAR_RPAREN);
      cls_new.is_comma      = (req_data.reply_char == CHAR_COMMA);
      cls_new.is_space      = (req_data.reply_char == CHAR_SPACE);
      cls_new.is_pasv       = (req_data.expected_code == CODE_PASV);
      cls_new.is_retr       = (req_data.expected_code == CODE_RETR);
      cls_new.last_char     = req_data.last_char;
      cls_new.expected_code = req_data.expected_code;
   end

   assign full      = (count_ff == CntW'(QUEUE_DEPTH));
   assign wr_en     = push && !full;
   assign cls_valid = (count_ff != '0);
   assign rd_en     = cls_valid && cls_take;
   assign cls_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_ff[wr_ptr_ff] <= cls_new;
      end
   end

endmodule

// File: rtl/fcrp_back.sv
// ----------------------------------------------------------------------------
// fcrp_back
// Runs the reply parse over classified characters and holds the result.
// ----------------------------------------------------------------------------
module fcrp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cls_valid,
   input  fcrp_pkg::cls_type cls_data,
   output logic              cls_take,
   output logic              empty,
   input  logic              pop,
   output fcrp_pkg::rsp_type rsp_data
);
   import fcrp_pkg::*;

   logic [1:0]  code_cnt_ff,   code_cnt_in;
   logic [9:0]  code_val_ff,   code_val_in;
   logic        code_bad_ff,   code_bad_in;
   logic        paren_ff,      paren_in;
   logic [2:0]  field_idx_ff,  field_idx_in;
   logic [31:0] field_acc_ff,  field_acc_in;
   logic [31:0] addr_acc_ff,   addr_acc_in;
   logic [15:0] port_acc_ff,   port_acc_in;
   logic [31:0] len_acc_ff,    len_acc_in;
   logic        done_ff,       done_in;
   logic        rsp_valid_ff,  rsp_valid_in;
   rsp_type     rsp_ff,        rsp_in;
   logic        step;
   logic        finish;
   logic        rsp_pop;
   status_type  status;
   logic [31:0] field_x10;
   logic [9:0]  code_x10;

   assign rsp_pop  = pop && rsp_valid_ff;
   assign cls_take = !cls_data.last_char || !rsp_valid_ff || rsp_pop;
   assign step     = cls_valid && cls_take;
   assign finish   = step && cls_data.last_char;
   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign field_x10 = {field_acc_ff[28:0], 3'b000} + {field_acc_ff[30:0], 1'b0}
                      + {28'd0, cls_data.digit};
   assign code_x10  = {code_val_ff[6:0], 3'b000} + {code_val_ff[8:0], 1'b0}
                      + {6'd0, cls_data.digit};

   always_comb begin
      code_cnt_in  = code_cnt_ff;
      code_val_in  = code_val_ff;
      code_bad_in  = code_bad_ff;
      paren_in     = paren_ff;
      field_idx_in = field_idx_ff;
      field_acc_in = field_acc_ff;
      addr_acc_in  = addr_acc_ff;
      port_acc_in  = port_acc_ff;
      len_acc_in   = len_acc_ff;
      done_in      = done_ff;

      if (code_cnt_ff != 2'd3) begin
         code_bad_in = code_bad_ff || !cls_data.is_digit;
         code_val_in = code_x10;
         code_cnt_in = code_cnt_ff + 1'b1;
      end else if (!done_ff && (cls_data.is_pasv || cls_data.is_retr)) begin
         if (!paren_ff) begin
            if (cls_data.is_lparen) begin
               paren_in     = 1'b1;
               field_acc_in = '0;
            end
         end else if (cls_data.is_digit) begin
            field_acc_in = field_x10;
         end else if (cls_data.is_pasv) begin
            if (cls_data.is_comma) begin
               if (field_idx_ff < 3'd4) begin
                  addr_acc_in  = {addr_acc_ff[23:0], field_acc_ff[7:0]};
                  field_idx_in = field_idx_ff + 1'b1;
               end else if (field_idx_ff == 3'd4) begin
                  port_acc_in  = {field_acc_ff[7:0], 8'd0};
                  field_idx_in = 3'd5;
               end
               field_acc_in = '0;
            end else if (cls_data.is_rparen && field_idx_ff == 3'd5) begin
               port_acc_in = {port_acc_ff[15:8], field_acc_ff[7:0]};
               done_in     = 1'b1;
            end
         end else if (cls_data.is_space) begin
            len_acc_in = field_acc_ff;
            done_in    = 1'b1;
         end
      end
   end

   always_comb begin
      if (code_bad_in || code_cnt_in != 2'd3 || code_val_in != cls_data.expected_code) begin
         status = STATUS_MISMATCH;
      end else if ((cls_data.is_pasv || cls_data.is_retr) && !done_in) begin
         status = STATUS_INCOMPLETE;
      end else begin
         status = STATUS_OK;
      end
      rsp_in.status      = status;
      rsp_in.reply_code  = code_val_in;
      rsp_in.ip_address  = (status == STATUS_OK && cls_data.is_pasv) ? addr_acc_in : 32'd0;
      rsp_in.port_number = (status == STATUS_OK && cls_data.is_pasv) ? port_acc_in : 16'd0;
      rsp_in.file_length = (status == STATUS_OK && cls_data.is_retr) ? len_acc_in : 32'd0;
      rsp_valid_in = finish || (rsp_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         code_cnt_ff  <= '0;
         code_val_ff  <= '0;
         code_bad_ff  <= 1'b0;
         paren_ff     <= 1'b0;
         field_idx_ff <= '0;
         field_acc_ff <= '0;
         addr_acc_ff  <= '0;
         port_acc_ff  <= '0;
         len_acc_ff   <= '0;
         done_ff      <= 1'b0;
      end else if (step) begin
         code_cnt_ff  <= code_cnt_in;
         code_val_ff  <= code_val_in;
         code_bad_ff  <= code_bad_in;
         paren_ff     <= paren_in;
         field_idx_ff <= field_idx_in;
         field_acc_ff <= field_acc_in;
         addr_acc_ff  <= addr_acc_in;
         port_acc_ff  <= port_acc_in;
         len_acc_ff   <= len_acc_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: rtl/ftp_control_reply_parser.sv
// ----------------------------------------------------------------------------
// ftp_control_reply_parser
// Checks the code of an FTP control reply and parses the passive address and
// port (227) or the file length (150), one result per reply.
//
//   channel   ports                      payload
//   request   push / full                req_data  (req_type)
//   response  empty / pop                rsp_data  (rsp_type)
//
// One character per cycle sustained; the front queue (two entries) feeds the
// parser, which retires one character per cycle.
// A result is registered on rsp_data when the parser takes its last
// character and holds until popped; a held result only stalls a further last
// character, other characters keep flowing until the queue fills.
// Reset is synchronous and clears the queue, parser state and result flag.
// ----------------------------------------------------------------------------
module ftp_control_reply_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  fcrp_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output fcrp_pkg::rsp_type rsp_data
);
   import fcrp_pkg::*;

   logic    cls_valid;
   logic    cls_take;
   cls_type cls_data;

   fcrp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cls_valid (cls_valid),
      .cls_data  (cls_data),
      .cls_take  (cls_take)
   );

   fcrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (cls_valid),
      .cls_data  (cls_data),
      .cls_take  (cls_take),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/fcrp_checker.sv
// ----------------------------------------------------------------------------
// fcrp_checker
// Port-level checks for the FTP control reply parser.
// ----------------------------------------------------------------------------
module fcrp_checker (
   input logic              clock,
   input logic              reset,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input fcrp_pkg::rsp_type rsp_data
);
   import fcrp_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("waiting result changed");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_data.status == STATUS_OK || rsp_data.status == STATUS_MISMATCH ||
                 rsp_data.status == STATUS_INCOMPLETE)
      else $error("illegal status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.status != STATUS_OK |->
         rsp_data.ip_address == '0 && rsp_data.port_number == '0 &&
         rsp_data.file_length == '0)
      else $error("failed reply carries fields");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.status != STATUS_MISMATCH |-> rsp_data.reply_code <= 10'd999)
      else $error("matched reply code out of range");

endmodule

bind ftp_control_reply_parser fcrp_checker u_fcrp_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
